@@ design/rls_pkg.sv @@
// ----------------------------------------------------------------------------
// rls_pkg
// Widths, register indexes and reset values shared by the ripeness scorer.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int LEVEL_W   = 14;
  localparam int OBJ_W     = 8;
  localparam int PROB_W    = 16;
  localparam int COEF_W    = 24;
  localparam int BIAS_W    = 28;
  localparam int FEAT_W    = 15;
  localparam int PROD_W    = COEF_W + FEAT_W;
  localparam int Z_W       = 41;
  localparam int DIV_W     = 42;
  localparam int NUM_COEF  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = BIAS_W;
  localparam int DIV_STEPS = PROB_W;
  localparam int FRONT_STAGES = 4;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STEPS;

  typedef logic [CFG_IDX_W-1:0]     cfg_index_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [Z_W-1:0]    logit_t;
  typedef logic [DIV_W-1:0]         div_t;
  typedef logic [PROB_W-1:0]        prob_t;

  localparam cfg_index_t REG_RED_COEF     = 3'd0;
  localparam cfg_index_t REG_GREEN_COEF   = 3'd1;
  localparam cfg_index_t REG_BLUE_COEF    = 3'd2;
  localparam cfg_index_t REG_AMBIENT_COEF = 3'd3;
  localparam cfg_index_t REG_WIDTH_COEF   = 3'd4;
  localparam cfg_index_t REG_FOLDED_BIAS  = 3'd5;

  localparam coef_t COEF_RESET [NUM_COEF] = '{
    -24'sd40184, 24'sd68874, 24'sd21614, -24'sd39579, -24'sd132721
  };
  localparam bias_t BIAS_RESET = 28'sd3933126;

endpackage

@@ design/rls_if.sv @@
// ----------------------------------------------------------------------------
// rls_if
// Valid/ready channels for the ripeness scorer: reading words in, scores out.
// ----------------------------------------------------------------------------
interface rls_in_if;
  logic                        valid;
  logic                        ready;
  logic [rls_pkg::LEVEL_W-1:0] red_level;
  logic [rls_pkg::LEVEL_W-1:0] green_level;
  logic [rls_pkg::LEVEL_W-1:0] blue_level;
  logic [rls_pkg::LEVEL_W-1:0] ambient_level;
  logic [rls_pkg::OBJ_W-1:0]   object_width;

  modport source (
    output valid, red_level, green_level, blue_level, ambient_level, object_width,
    input  ready
  );
  modport sink (
    input  valid, red_level, green_level, blue_level, ambient_level, object_width,
    output ready
  );
endinterface

interface rls_out_if;
  logic                       valid;
  logic                       ready;
  logic [rls_pkg::PROB_W-1:0] ripe_probability;

  modport source (output valid, ripe_probability, input ready);
  modport sink (input valid, ripe_probability, output ready);
endinterface

@@ design/ripeness_logistic_scorer.sv @@
// ----------------------------------------------------------------------------
// ripeness_logistic_scorer
// Pipelined logistic scorer with a softsign squashing stage.
//
// A word on in_word carries four Q10.4 light readings and an object width.
// The block forms the logit from five coefficients and a folded bias, then
// returns the ripe probability 0.5*(1 - z/(1+|z|)) as Q0.16 on out_word.
// The cfg port writes one coefficient or the bias per cycle; the user must
// write it only while idle, as the block itself does not enforce this. The
// pipeline has 20 register stages: one multiply stage, two adder stages,
// one magnitude stage and a 16-stage restoring divider that resolves one
// quotient bit per stage. The block takes one word per cycle unless out_word
// stalls: when out_word holds a word the receiver does not take, every stage
// freezes together and in_word.ready falls; nothing is lost.
// Reset empties the pipeline and restores the default coefficients and bias.
// ----------------------------------------------------------------------------
module ripeness_logistic_scorer #(
  parameter int FRACTION_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rls_in_if.sink                      in_word,
  rls_out_if.source                   out_word,
  input  logic                        cfg_we,
  input  logic [rls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rls_pkg::CFG_DAT_W-1:0] cfg_data
);
  import rls_pkg::*;

  localparam div_t SCALE = div_t'(1) << (FRACTION_BITS + 4);

  coef_t  coef_r [NUM_COEF];
  bias_t  bias_r;

  logic   vld_r [PIPE_DEPTH];
  logic   pipe_en;

  prod_t  prod_r [NUM_COEF];
  logit_t bias16_r;
  logit_t psum_r [3];
  logit_t z_r;
  div_t   num_r;
  div_t   den_r;
  logic   neg_r;

  div_t   div_rem_r [DIV_STEPS];
  div_t   div_den_r [DIV_STEPS];
  prob_t  div_quo_r [DIV_STEPS];
  logic   div_neg_r [DIV_STEPS];

  logic signed [FEAT_W-1:0] feat [NUM_COEF];
  div_t   mag;
  div_t   rem_nxt [DIV_STEPS];
  prob_t  quo_nxt [DIV_STEPS];

  assign pipe_en       = !out_word.valid || out_word.ready;
  assign in_word.ready = pipe_en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= COEF_RESET[i];
      end
      bias_r <= BIAS_RESET;
    end else if (cfg_we) begin
      case (cfg_index) inside
        [REG_RED_COEF:REG_WIDTH_COEF]: coef_r[cfg_index] <= cfg_data[COEF_W-1:0];
        REG_FOLDED_BIAS:               bias_r <= cfg_data[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (pipe_en) begin
      vld_r[0] <= in_word.valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_comb begin
    feat[0] = $signed({1'b0, in_word.red_level});
    feat[1] = $signed({1'b0, in_word.green_level});
    feat[2] = $signed({1'b0, in_word.blue_level});
    feat[3] = $signed({1'b0, in_word.ambient_level});
    feat[4] = $signed({3'b000, in_word.object_width, 4'b0000});
  end

  assign mag = z_r[Z_W-1] ? div_t'(-z_r) : div_t'(z_r);

  // One restoring step per stage; the first step compares without a shift.
  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      div_t trial;
      if (k == 0) begin
        trial = num_r;
        if (trial >= den_r) begin
          rem_nxt[k] = trial - den_r;
          quo_nxt[k] = prob_t'(1);
        end else begin
          rem_nxt[k] = trial;
          quo_nxt[k] = '0;
        end
      end else begin
        trial = {div_rem_r[k-1][DIV_W-2:0], 1'b0};
        if (trial >= div_den_r[k-1]) begin
          rem_nxt[k] = trial - div_den_r[k-1];
          quo_nxt[k] = {div_quo_r[k-1][PROB_W-2:0], 1'b1};
        end else begin
          rem_nxt[k] = trial;
          quo_nxt[k] = {div_quo_r[k-1][PROB_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        prod_r[i] <= prod_t'(coef_r[i]) * prod_t'(feat[i]);
      end
      bias16_r  <= logit_t'($signed({bias_r, 4'b0000}));
      psum_r[0] <= logit_t'(prod_r[0]) + logit_t'(prod_r[1]);
      psum_r[1] <= logit_t'(prod_r[2]) + logit_t'(prod_r[3]);
      psum_r[2] <= logit_t'(prod_r[4]) + bias16_r;
      z_r       <= psum_r[0] + psum_r[1] + psum_r[2];
      neg_r     <= z_r[Z_W-1];
      den_r     <= SCALE + mag;
      num_r     <= z_r[Z_W-1] ? SCALE + {mag[DIV_W-2:0], 1'b0} : SCALE;
      div_rem_r[0] <= rem_nxt[0];
      div_den_r[0] <= den_r;
      div_quo_r[0] <= quo_nxt[0];
      div_neg_r[0] <= neg_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        div_rem_r[k] <= rem_nxt[k];
        div_den_r[k] <= div_den_r[k-1];
        div_quo_r[k] <= quo_nxt[k];
        div_neg_r[k] <= div_neg_r[k-1];
      end
    end
  end

  assign out_word.valid            = vld_r[PIPE_DEPTH-1];
  assign out_word.ripe_probability = div_quo_r[DIV_STEPS-1];

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_word.valid)
    else $error("output word valid right after reset");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> div_rem_r[DIV_STEPS-1] < div_den_r[DIV_STEPS-1])
    else $error("divider remainder not below divisor");

  a_neg_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && div_neg_r[DIV_STEPS-1]) |-> out_word.ripe_probability >= 16'h8000)
    else $error("negative logit scored below one half");

  a_pos_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_word.valid && !div_neg_r[DIV_STEPS-1]) |-> out_word.ripe_probability <= 16'h8000)
    else $error("non-negative logit scored above one half");

endmodule

@@ tb/rls_score_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rls_score_checker
// Watches both channels of the ripeness scorer and the cfg port. It mirrors
// the coefficient and bias registers, scores every accepted reading word
// with an exact fixed-point softsign logistic evaluation, and compares each
// returned score word in order against the oldest score still due.
// ----------------------------------------------------------------------------
module rls_score_checker #(
  parameter int FRACTION_BITS = 20,
  parameter int MAX_REPORTS   = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rls_in_if                             in_mon,
  rls_out_if                            out_mon,
  input  logic                          cfg_we,
  input  rls_pkg::cfg_index_t           cfg_index,
  input  logic [rls_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            pending,
  output int                            scored,
  output int                            saturated,
  output int                            fail_count
);
  import rls_pkg::*;

  typedef longint unsigned wide_t;

  localparam wide_t UNITY    = wide_t'(1) << (FRACTION_BITS + 4);
  localparam wide_t HALF     = wide_t'(1) << (PROB_W - 1);
  localparam wide_t PROB_MAX = (wide_t'(1) << PROB_W) - 1;

  coef_t coef_mirror [NUM_COEF];
  bias_t bias_mirror;
  prob_t ripe_prob_due [$];
  int    errors;
  int    checked;
  int    clipped;

  // The logit is held exactly with FRACTION_BITS+4 fraction bits, so the
  // readings enter as they are and the width and bias are scaled by 16.
  function automatic prob_t softsign_score(input logic [LEVEL_W-1:0] red,
                                           input logic [LEVEL_W-1:0] green,
                                           input logic [LEVEL_W-1:0] blue,
                                           input logic [LEVEL_W-1:0] ambient,
                                           input logic [OBJ_W-1:0]   obj_width);
    longint feature [NUM_COEF];
    longint logit;
    wide_t  mag;
    wide_t  num;
    wide_t  den;
    wide_t  quot;
    feature[0] = longint'(red);
    feature[1] = longint'(green);
    feature[2] = longint'(blue);
    feature[3] = longint'(ambient);
    feature[4] = longint'(obj_width) * 16;
    logit = longint'(bias_mirror) * 16;
    for (int i = 0; i < NUM_COEF; i++) begin
      logit += longint'(coef_mirror[i]) * feature[i];
    end
    mag  = (logit < 0) ? -logit : logit;
    den  = UNITY + mag;
    num  = (logit < 0) ? UNITY + 2 * mag : UNITY;
    quot = (num * HALF) / den;
    if (quot > PROB_MAX) begin
      quot = PROB_MAX;
    end
    return prob_t'(quot);
  endfunction

  always @(posedge clk) begin
    prob_t expected;
    if (!rst_n) begin
      foreach (coef_mirror[i]) coef_mirror[i] = COEF_RESET[i];
      bias_mirror = BIAS_RESET;
      ripe_prob_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RED_COEF, REG_GREEN_COEF, REG_BLUE_COEF, REG_AMBIENT_COEF,
          REG_WIDTH_COEF: begin
            coef_mirror[cfg_index] = coef_t'(cfg_data[COEF_W-1:0]);
          end
          REG_FOLDED_BIAS: begin
            bias_mirror = bias_t'(cfg_data);
          end
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        ripe_prob_due.push_back(softsign_score(in_mon.red_level, in_mon.green_level,
                                               in_mon.blue_level, in_mon.ambient_level,
                                               in_mon.object_width));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (ripe_prob_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: ripe_probability expected none, got %0d", $time,
                     out_mon.ripe_probability);
          end
        end else begin
          expected = ripe_prob_due.pop_front();
          checked++;
          if (expected == prob_t'(PROB_MAX)) begin
            clipped++;
          end
          if (out_mon.ripe_probability !== expected) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: ripe_probability expected %0d, got %0d", $time, expected,
                       out_mon.ripe_probability);
            end
          end
        end
      end
    end
    pending    <= ripe_prob_due.size();
    scored     <= checked;
    saturated  <= clipped;
    fail_count <= errors;
  end

endmodule

@@ tb/tb_ripeness_logistic_scorer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ripeness_logistic_scorer
// Drives reading words into the ripeness scorer under default, extreme and
// random register settings, with random gaps on the sender and random stalls
// on the receiver. A side checker predicts every score and counts failures.
// ----------------------------------------------------------------------------
module tb_ripeness_logistic_scorer;
  import rls_pkg::*;

  localparam int FRACTION_BITS = 20;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_WORDS  = 1932;
  localparam int PHASES        = 6;
  localparam int REPICK_EVERY  = 80;
  localparam int PAUSE_AT      = 150;
  localparam int TIMEOUT_NS    = 4_000_000;

  localparam cfg_index_t SPARE_REG_LO = 3'd6;
  localparam cfg_index_t SPARE_REG_HI = 3'd7;
  localparam cfg_index_t COEF_REG [NUM_COEF] = '{
    REG_RED_COEF, REG_GREEN_COEF, REG_BLUE_COEF, REG_AMBIENT_COEF, REG_WIDTH_COEF
  };

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  localparam logic [OBJ_W-1:0]   OBJ_MAX   = '1;
  localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam bias_t BIAS_MAX = {1'b0, {(BIAS_W-1){1'b1}}};
  localparam bias_t BIAS_MIN = {1'b1, {(BIAS_W-1){1'b0}}};

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] ambient;
    logic [OBJ_W-1:0]   obj_width;
  } reading_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_index_t           cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  bit    source_idle;
  bit    sink_idle;
  int    stall_left;
  int    pending;
  int    scored;
  int    saturated;
  int    fail_count;
  int    words_sent;
  int    settings_loaded;
  coef_t coef_plan [NUM_COEF];
  bias_t bias_plan;

  rls_in_if  in_word ();
  rls_out_if out_word ();

  ripeness_logistic_scorer #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  rls_score_checker #(
    .FRACTION_BITS(FRACTION_BITS)
  ) score_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_word),
    .out_mon   (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .scored    (scored),
    .saturated (saturated),
    .fail_count(fail_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap(input bit enabled);
    int roll;
    if (!enabled) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_signed(input int bits);
    return int'($urandom_range(0, (32'd1 << (bits + 1)) - 1)) - (1 << bits);
  endfunction

  function automatic reading_t make_reading(input logic [LEVEL_W-1:0] red,
                                            input logic [LEVEL_W-1:0] green,
                                            input logic [LEVEL_W-1:0] blue,
                                            input logic [LEVEL_W-1:0] ambient,
                                            input logic [OBJ_W-1:0]   obj_width);
    reading_t w;
    w.red       = red;
    w.green     = green;
    w.blue      = blue;
    w.ambient   = ambient;
    w.obj_width = obj_width;
    return w;
  endfunction

  function automatic logic [LEVEL_W-1:0] pin_level(input logic [LEVEL_W-1:0] v);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return LEVEL_MAX;
      default: return v;
    endcase
  endfunction

  function automatic reading_t random_reading();
    reading_t w;
    int       roll;
    w    = reading_t'({$urandom, $urandom});
    roll = $urandom_range(0, 9);
    if (roll >= 8) begin
      w = make_reading(LEVEL_W'($urandom_range(0, 2047)), LEVEL_W'($urandom_range(0, 2047)),
                       LEVEL_W'($urandom_range(0, 2047)), LEVEL_W'($urandom_range(0, 511)),
                       OBJ_W'($urandom_range(20, 120)));
    end else if (roll >= 6) begin
      w.red       = pin_level(w.red);
      w.green     = pin_level(w.green);
      w.blue      = pin_level(w.blue);
      w.ambient   = pin_level(w.ambient);
      w.obj_width = ($urandom_range(0, 2) == 0) ? '0 :
                    ($urandom_range(0, 1) == 0) ? OBJ_MAX : w.obj_width;
    end
    return w;
  endfunction

  // Small coefficients keep the logit near zero, where the score moves most.
  function automatic void pick_regs(input int kind);
    int bits;
    bits = (kind == 0) ? 12 : (kind == 1) ? 17 : COEF_W - 1;
    foreach (coef_plan[i]) coef_plan[i] = coef_t'(rand_signed(bits));
    bias_plan = bias_t'(rand_signed((kind == 2) ? BIAS_W - 1 : bits + 8));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_word.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left > 0) begin
      out_word.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else begin
      out_word.ready <= 1'b1;
      stall_left     <= pick_gap(sink_idle);
    end
  end

  task automatic send_word(input reading_t w);
    int gap;
    gap = pick_gap(source_idle);
    if (gap > 0) begin
      in_word.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_word.valid         <= 1'b1;
    in_word.red_level     <= w.red;
    in_word.green_level   <= w.green;
    in_word.blue_level    <= w.blue;
    in_word.ambient_level <= w.ambient;
    in_word.object_width  <= w.obj_width;
    do @(posedge clk); while (!in_word.ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_word.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Coefficient writes carry random bits above the register width, and the
  // two unused indexes get junk; the block must ignore both.
  task automatic load_regs();
    logic [CFG_DAT_W-COEF_W-1:0] junk;
    for (int i = 0; i < NUM_COEF; i++) begin
      junk = (CFG_DAT_W-COEF_W)'($urandom);
      write_reg(COEF_REG[i], {junk, coef_plan[i]});
    end
    write_reg(REG_FOLDED_BIAS, bias_plan);
    write_reg(SPARE_REG_LO, CFG_DAT_W'($urandom));
    write_reg(SPARE_REG_HI, CFG_DAT_W'($urandom));
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_RED_COEF;
    cfg_data              = '0;
    in_word.valid         = 1'b0;
    in_word.red_level     = '0;
    in_word.green_level   = '0;
    in_word.blue_level    = '0;
    in_word.ambient_level = '0;
    in_word.object_width  = '0;
    source_idle           = 1'b0;
    sink_idle             = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_reading('0, '0, '0, '0, '0));
    send_word(make_reading(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, OBJ_MAX));
    send_word(make_reading(LEVEL_MAX, '0, '0, '0, '0));
    send_word(make_reading('0, LEVEL_MAX, '0, '0, '0));
    send_word(make_reading('0, '0, LEVEL_MAX, '0, '0));
    send_word(make_reading('0, '0, '0, LEVEL_MAX, '0));
    send_word(make_reading('0, '0, '0, '0, OBJ_MAX));
    send_word(make_reading(14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555, 8'hAA));
    send_word(make_reading(14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA, 8'h55));

    wait_drained();
    foreach (coef_plan[i]) coef_plan[i] = COEF_MAX;
    bias_plan = BIAS_MAX;
    load_regs();
    send_word(make_reading(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, OBJ_MAX));
    send_word(make_reading('0, '0, '0, '0, '0));

    // Most negative logit on the first word: its score reaches full scale.
    wait_drained();
    foreach (coef_plan[i]) coef_plan[i] = COEF_MIN;
    bias_plan = BIAS_MIN;
    load_regs();
    send_word(make_reading(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, OBJ_MAX));
    send_word(make_reading('0, '0, '0, '0, '0));

    wait_drained();
    foreach (coef_plan[i]) coef_plan[i] = '0;
    bias_plan = '0;
    load_regs();
    send_word(random_reading());
    send_word(make_reading(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, OBJ_MAX));

    wait_drained();
    foreach (coef_plan[i]) coef_plan[i] = (i % 2 == 0) ? COEF_MAX : COEF_MIN;
    bias_plan = '0;
    load_regs();
    send_word(make_reading(LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, OBJ_MAX));
    send_word(make_reading('0, LEVEL_MAX, '0, LEVEL_MAX, '0));

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      pick_regs(phase % 3);
      load_regs();
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
        if (n % REPICK_EVERY == 0) begin
          source_idle = (phase == 0 && n == 0) ? 1'b0 : 1'($urandom_range(0, 1));
          sink_idle  <= (phase == 0 && n == 0) ? 1'b0 : 1'($urandom_range(0, 1));
        end
        if (n == PAUSE_AT) begin
          wait_drained();
        end
        send_word(random_reading());
      end
    end

    sink_idle <= 1'b0;
    wait_drained();
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("Sent %0d reading words through %0d register settings, with gaps and stalls.",
             words_sent, settings_loaded);
    $display("Checked %0d scores, %0d of them saturated at full scale.", scored, saturated);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
design/rls_pkg.sv
design/rls_if.sv
design/ripeness_logistic_scorer.sv
tb/rls_score_checker.sv
tb/tb_ripeness_logistic_scorer.sv
